>>> rtl/sep_pkg.sv
`default_nettype none

package sep_pkg;

    // Threshold register
    localparam int THRESH_W = 7;
    localparam logic [THRESH_W-1:0] THRESH_RESET = 7'd11;

    // Result queue: must take two results per item and still sustain one item a cycle while the output is free
    localparam int QUEUE_DEPTH = 4;
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    // Input stage may advance while the queue holds at most this many items
    localparam logic [CNT_W-1:0] ADVANCE_MAX = CNT_W'(QUEUE_DEPTH - 2);

    localparam logic [3:0] NIB_MASK = 4'hF;

    typedef struct packed {
        logic [7:0] upper_byte;
        logic [7:0] centre_byte;
        logic [7:0] lower_byte;
        logic       row_end;
    } t_in_item;

    typedef struct packed {
        logic [7:0] packed_result;
        logic       row_last;
    } t_out_item;

    // Three nibbles of one image column: [11:8] upper, [7:4] centre, [3:0] lower
    typedef logic [11:0] t_nib3;

    function automatic logic signed [8:0] ext9(input logic [3:0] x);
        ext9 = signed'({5'b0, x});
    endfunction

    // Gx+Gy of one 3x3 window, thresholded, low four bits kept
    function automatic logic [3:0] sobel_nibble(input t_nib3 l, input t_nib3 m,
                                                input t_nib3 r,
                                                input logic [THRESH_W-1:0] thr);
        logic signed [8:0] gx;
        logic signed [8:0] gy;
        logic signed [8:0] sum;
        gx = ext9(r[11:8]) - ext9(l[11:8])
           + (ext9(r[7:4]) <<< 1) - (ext9(l[7:4]) <<< 1)
           + ext9(r[3:0]) - ext9(l[3:0]);
        gy = ext9(l[3:0]) + (ext9(m[3:0]) <<< 1) + ext9(r[3:0])
           - ext9(l[11:8]) - (ext9(m[11:8]) <<< 1) - ext9(r[11:8]);
        sum = gx + gy;
        if (sum < signed'({2'b0, thr})) begin
            sum = '0;
        end
        sobel_nibble = sum[3:0] & NIB_MASK;
    endfunction

    function automatic t_nib3 high_nibbles(input logic [23:0] col);
        high_nibbles = {col[23:20], col[15:12], col[7:4]};
    endfunction

    function automatic t_nib3 low_nibbles(input logic [23:0] col);
        low_nibbles = {col[19:16], col[11:8], col[3:0]};
    endfunction

    // Output byte of a column: even pixel in the high nibble, odd pixel in the low
    function automatic logic [7:0] column_byte(input logic [23:0] col,
                                               input t_nib3 left_low,
                                               input logic [23:0] right_col,
                                               input logic [THRESH_W-1:0] thr);
        t_nib3 hi;
        t_nib3 lo;
        hi = high_nibbles(col);
        lo = low_nibbles(col);
        column_byte = {sobel_nibble(left_low, hi, lo, thr),
                       sobel_nibble(hi, lo, high_nibbles(right_col), thr)};
    endfunction

endpackage

`default_nettype wire

>>> rtl/sobel_edge_packed_nibble.sv
`default_nettype none

// Channel | Direction | Handshake               | Payload
// in      | input     | i_in_valid / o_in_stall   | i_in_data  (t_in_item)
// out     | output    | o_out_valid / i_out_stall | o_out_data (t_out_item)
// cfg     | input     | i_cfg_valid / o_cfg_ready | i_cfg_data (edge threshold)
//
// One column item per clock sustained while the output is free; results leave through the
// input register and then the queue once the item that releases them is taken.
// A row's first column gives no result unless it ends the row; a row_end column after
// a pending one gives two. The queue absorbs that burst, so a free output never stalls.
// Reset is synchronous, active low; it empties the pipeline and the queue and sets the
// threshold to 11. Input stalls only while the input register is full and the queue holds 3+.
module sobel_edge_packed_nibble (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_in_valid,
    output logic                      o_in_stall,
    input  sep_pkg::t_in_item         i_in_data,
    output logic                      o_out_valid,
    input  wire                       i_out_stall,
    output sep_pkg::t_out_item        o_out_data,
    input  wire                       i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire [sep_pkg::THRESH_W-1:0] i_cfg_data
);
    import sep_pkg::*;

    logic [THRESH_W-1:0] r_thresh;

    logic      r_in_valid, n_in_valid;
    t_in_item  r_in;

    logic [23:0] r_pend_col;
    logic        r_pend_valid, n_pend_valid;
    t_nib3       r_left_low, n_left_low;

    t_out_item        r_q [QUEUE_DEPTH];
    t_out_item        n_q [QUEUE_DEPTH];
    logic [CNT_W-1:0] r_cnt, n_cnt;

    logic        in_acc, advance, pop;
    logic [23:0] col;
    t_nib3       left_for_last;
    t_out_item   res_pend, res_last, push0, push1;
    logic [1:0]  n_push;
    logic [CNT_W-1:0] base;

    // Configuration register
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thresh <= THRESH_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_thresh <= i_cfg_data;
        end
    end

    // Input register handshake
    assign advance    = (r_cnt <= ADVANCE_MAX);
    assign o_in_stall = r_in_valid && !advance;
    assign in_acc     = i_in_valid && !o_in_stall;

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_acc) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= n_in_valid;
        end
        if (in_acc) begin
            r_in <= i_in_data;
        end
    end

    // Sobel results for the pending column and for a row_end column
    assign col           = {r_in.upper_byte, r_in.centre_byte, r_in.lower_byte};
    assign left_for_last = r_pend_valid ? low_nibbles(r_pend_col) : r_left_low;

    always_comb begin
        res_pend.packed_result = column_byte(r_pend_col, r_left_low, col, r_thresh);
        res_pend.row_last      = 1'b0;
        res_last.packed_result = column_byte(col, left_for_last, 24'd0, r_thresh);
        res_last.row_last      = 1'b1;
    end

    // Order the pushes: pending column first, then the row_end column
    always_comb begin
        push0  = res_last;
        push1  = res_last;
        n_push = 2'd0;
        if (r_in_valid && advance) begin
            n_push = {1'b0, r_pend_valid} + {1'b0, r_in.row_end};
            if (r_pend_valid) begin
                push0 = res_pend;
            end
        end
    end

    // Column state update
    always_comb begin
        n_pend_valid = r_pend_valid;
        n_left_low   = r_left_low;
        if (r_in_valid && advance) begin
            if (r_in.row_end) begin
                n_pend_valid = 1'b0;
                n_left_low   = '0;
            end else begin
                n_pend_valid = 1'b1;
                if (r_pend_valid) begin
                    n_left_low = low_nibbles(r_pend_col);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend_valid <= 1'b0;
            r_left_low   <= '0;
        end else begin
            r_pend_valid <= n_pend_valid;
            r_left_low   <= n_left_low;
        end
        if (r_in_valid && advance && !r_in.row_end) begin
            r_pend_col <= col;
        end
    end

    // Result queue: shift register, head at slot 0
    assign o_out_valid = (r_cnt != '0);
    assign o_out_data  = r_q[0];
    assign pop         = o_out_valid && !i_out_stall;
    assign base        = r_cnt - CNT_W'(pop);

    always_comb begin
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            if (pop && i < QUEUE_DEPTH - 1) begin
                n_q[i] = r_q[i + 1];
            end else begin
                n_q[i] = r_q[i];
            end
        end
        if (n_push != 2'd0) begin
            n_q[base[IDX_W-1:0]] = push0;
        end
        if (n_push == 2'd2) begin
            n_q[base[IDX_W-1:0] + IDX_W'(1)] = push1;
        end
        n_cnt = base + CNT_W'(n_push);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
        end else begin
            r_cnt <= n_cnt;
        end
        for (int i = 0; i < QUEUE_DEPTH; i++) begin
            r_q[i] <= n_q[i];
        end
    end

endmodule

`default_nettype wire

>>> rtl/sep_checker.sv
`default_nettype none

module sep_checker (
    input wire                         i_clk,
    input wire                         i_rst_n,
    input wire                         i_in_valid,
    input wire                         o_in_stall,
    input wire                         o_out_valid,
    input wire                         i_out_stall,
    input sep_pkg::t_out_item          o_out_data
);
    import sep_pkg::*;

    // Reset empties the result queue
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid right after reset");

    // Input is held back only when results are waiting
    a_stall_has_output: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> o_out_valid)
        else $error("input stalled with empty result queue");

    // A result appears on an empty output only for an item taken through the input register into the queue
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(i_in_valid && !o_in_stall, 2))
        else $error("result appeared without an item taken two cycles earlier");

    // A stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_data))
        else $error("stalled result changed");

endmodule

bind sobel_edge_packed_nibble sep_checker u_sep_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
